### rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sfr_pkg.sv
// Types, constants and helper functions for the stuffed frame receiver
package sfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 24;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned CMD_W  = 32;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned KIND_W = 3;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 10'd18;
  localparam logic [LEN_W-1:0] ADDR_BYTES      = 10'd3;
  localparam logic [LEN_W-1:0] LEN_DIGITS      = 10'd3;
  localparam logic [LEN_W-1:0] CMD_BYTES       = 10'd4;
  localparam logic [LEN_W-1:0] CRC_DIGITS      = 10'd4;

  localparam logic [ADDR_W-1:0] OWN_ADDR_RST = 24'h53544D;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 10'd700;

  typedef enum logic {
    CFG_OWN_ADDR = 1'b0,
    CFG_MAX_LEN  = 1'b1
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PARAM   = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_CRC_ERR = 3'd2,
    KIND_ESC_ERR = 3'd3,
    KIND_LEN_ERR = 3'd4,
    KIND_SHORT   = 3'd5,
    KIND_NULL    = 3'd6,
    KIND_DROP    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_SENDER   = 3'd1,
    PH_RECEIVER = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_COMMAND  = 3'd4,
    PH_PARAM    = 3'd5,
    PH_CRC      = 3'd6,
    PH_FOOTER   = 3'd7
  } phase_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
  } evt_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {r[CRC_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [BYTE_W-1:0] b);
    return is_digit(b) || ((b >= CH_UA) && (b <= CH_UF)) || ((b >= CH_LA) && (b <= CH_LF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] b);
    return is_digit(b) ? b[3:0] : (b[3:0] + 4'd9);
  endfunction

endpackage

### rtl/stuffed_frame_receiver_crc16.sv
// Byte-stuffed frame receiver with CRC-16/CCITT-FALSE check, top level
// Takes one raw byte per clock and returns at most one result per byte: each
// accepted parameter digit, then one status at the end of a frame (good, CRC
// error, escape error, length error, short frame, drop), plus a null
// notice for every zero byte. Sustained rate is one byte per cycle while the
// result side is not stalling; a stalled result also holds the input. A byte
// is held in the input register until it advances, and its result is then
// presented from the result register. The whole per-byte update, including an
// unrolled 8-bit CRC step, sits between those two registers. Configuration
// must only be written while no byte or result is in flight.
module stuffed_frame_receiver_crc16
  import sfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KIND_W-1:0]   out_kind,
  output logic [BYTE_W-1:0]   out_param_digit,
  output logic [ADDR_W-1:0]   out_sender,
  output logic [CMD_W-1:0]    out_command_word,
  output logic [LEN_W-1:0]    out_param_count,
  output logic [CRC_W-1:0]    out_computed_crc,
  input  logic                cfg_wr_en,
  input  cfg_idx_t            cfg_index,
  input  logic [ADDR_W-1:0]   cfg_wdata
);

`include "assert_macros.svh"

  logic               in_vld_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic [ADDR_W-1:0]  own_addr_r;
  logic [LEN_W-1:0]   max_len_r;

  phase_t             phase_r, phase_nxt;
  logic               esc_r, esc_nxt;
  logic [CRC_W-1:0]   crc_r, crc_nxt;
  logic [LEN_W-1:0]   fbc_r, fbc_nxt;
  logic [LEN_W-1:0]   fidx_r, fidx_nxt;
  logic [LEN_W-1:0]   dlen_r, dlen_nxt;
  logic [ADDR_W-1:0]  sender_r, sender_nxt;
  logic [ADDR_W-1:0]  recv_r, recv_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [CRC_W-1:0]   rcrc_r, rcrc_nxt;

  logic               out_vld_r;
  kind_t              out_kind_r;
  logic [BYTE_W-1:0]  out_digit_r;
  logic [ADDR_W-1:0]  out_sender_r;
  logic [CMD_W-1:0]   out_cmd_r;
  logic [LEN_W-1:0]   out_count_r;
  logic [CRC_W-1:0]   out_crc_r;

  logic               adv;
  logic               fopen;
  logic               esc_bad;
  logic [BYTE_W-1:0]  bd;
  logic [CRC_W-1:0]   crc_upd;
  logic [LEN_W-1:0]   fidx_inc;
  logic [LEN_W-1:0]   dl_base;
  logic [13:0]        dl_mul;
  logic [LEN_W-1:0]   dlen_rpt;
  logic               frm_rst;
  evt_t               evt;

  kind_t              res_kind;
  logic [BYTE_W-1:0]  res_digit;
  logic [CMD_W-1:0]   res_cmd;
  logic [CRC_W-1:0]   res_crc;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  // unstuffing of the held byte
  always_comb begin : unstuff
    esc_bad = 1'b0;
    bd      = in_byte_r;
    if (esc_r) begin
      unique case (in_byte_r)
        CH_LBRK:  bd = CH_OPEN;
        CH_RBRK:  bd = CH_CLOSE;
        CH_CARET: bd = CH_TILDE;
        default:  esc_bad = 1'b1;
      endcase
    end
  end

  assign fopen    = (fbc_r != '0);
  assign crc_upd  = crc16_byte(crc_r, bd);
  assign fidx_inc = fidx_r + 10'd1;
  assign dl_base  = (fidx_r == '0) ? '0 : dlen_r;
  assign dl_mul   = {1'b0, dl_base, 3'b000} + {3'b000, dl_base, 1'b0} + {10'd0, bd[3:0]};

  // next state
  always_comb begin : next_state
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    crc_nxt    = crc_r;
    fbc_nxt    = fbc_r;
    fidx_nxt   = fidx_r;
    dlen_nxt   = dlen_r;
    sender_nxt = sender_r;
    recv_nxt   = recv_r;
    cmd_nxt    = cmd_r;
    rcrc_nxt   = rcrc_r;
    frm_rst    = 1'b0;
    evt        = '{vld: 1'b0, kind: KIND_NULL};

    if (in_byte_r == CH_NUL) begin
      evt = '{vld: 1'b1, kind: KIND_NULL};
    end else if (!fopen && in_byte_r != CH_OPEN) begin
      // idle line noise
    end else if (fopen && in_byte_r == CH_OPEN) begin
      // restart on a fresh header
      phase_nxt = PH_SENDER;
      esc_nxt   = 1'b0;
      crc_nxt   = CRC_INIT;
      fbc_nxt   = 10'd1;
      fidx_nxt  = '0;
      dlen_nxt  = '0;
    end else if (fopen && fbc_r < MIN_FRAME_BYTES && in_byte_r == CH_CLOSE) begin
      evt     = '{vld: 1'b1, kind: KIND_SHORT};
      frm_rst = 1'b1;
    end else if (fopen && in_byte_r == CH_TILDE) begin
      esc_nxt = 1'b1;
    end else if (esc_bad) begin
      evt     = '{vld: 1'b1, kind: KIND_ESC_ERR};
      frm_rst = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      unique case (phase_r)
        PH_HEADER: begin
          phase_nxt = PH_SENDER;
          fbc_nxt   = 10'd1;
        end
        PH_SENDER: begin
          crc_nxt    = crc_upd;
          fbc_nxt    = fbc_r + 10'd1;
          sender_nxt = {sender_r[ADDR_W-BYTE_W-1:0], bd};
          if (fidx_inc >= ADDR_BYTES) begin
            fidx_nxt  = '0;
            phase_nxt = PH_RECEIVER;
          end else begin
            fidx_nxt = fidx_inc;
          end
        end
        PH_RECEIVER: begin
          crc_nxt  = crc_upd;
          fbc_nxt  = fbc_r + 10'd1;
          recv_nxt = {recv_r[ADDR_W-BYTE_W-1:0], bd};
          if (fidx_inc >= ADDR_BYTES) begin
            if (recv_nxt != own_addr_r) begin
              evt     = '{vld: 1'b1, kind: KIND_DROP};
              frm_rst = 1'b1;
            end else begin
              fidx_nxt  = '0;
              phase_nxt = PH_LENGTH;
            end
          end else begin
            fidx_nxt = fidx_inc;
          end
        end
        PH_LENGTH: begin
          if (!is_digit(bd)) begin
            evt     = '{vld: 1'b1, kind: KIND_DROP};
            frm_rst = 1'b1;
          end else begin
            crc_nxt  = crc_upd;
            fbc_nxt  = fbc_r + 10'd1;
            dlen_nxt = dl_mul[LEN_W-1:0];
            if (fidx_inc >= LEN_DIGITS) begin
              if (dlen_nxt > max_len_r) begin
                evt     = '{vld: 1'b1, kind: KIND_LEN_ERR};
                frm_rst = 1'b1;
              end else begin
                fidx_nxt  = '0;
                phase_nxt = PH_COMMAND;
              end
            end else begin
              fidx_nxt = fidx_inc;
            end
          end
        end
        PH_COMMAND: begin
          crc_nxt = crc_upd;
          fbc_nxt = fbc_r + 10'd1;
          cmd_nxt = {cmd_r[CMD_W-BYTE_W-1:0], bd};
          if (fidx_inc >= CMD_BYTES) begin
            fidx_nxt  = '0;
            phase_nxt = (dlen_r == '0) ? PH_CRC : PH_PARAM;
          end else begin
            fidx_nxt = fidx_inc;
          end
        end
        PH_PARAM: begin
          if (!is_digit(bd)) begin
            evt     = '{vld: 1'b1, kind: KIND_DROP};
            frm_rst = 1'b1;
          end else begin
            crc_nxt = crc_upd;
            fbc_nxt = fbc_r + 10'd1;
            evt     = '{vld: 1'b1, kind: KIND_PARAM};
            if (fidx_inc >= dlen_r) begin
              fidx_nxt  = '0;
              phase_nxt = PH_CRC;
            end else begin
              fidx_nxt = fidx_inc;
            end
          end
        end
        PH_CRC: begin
          if (!is_hex(bd)) begin
            evt     = '{vld: 1'b1, kind: KIND_DROP};
            frm_rst = 1'b1;
          end else begin
            fbc_nxt  = fbc_r + 10'd1;
            rcrc_nxt = {rcrc_r[CRC_W-5:0], hex_val(bd)};
            if (fidx_inc >= CRC_DIGITS) begin
              fidx_nxt  = '0;
              phase_nxt = PH_FOOTER;
            end else begin
              fidx_nxt = fidx_inc;
            end
          end
        end
        PH_FOOTER: begin
          frm_rst = 1'b1;
          if (bd != CH_CLOSE) begin
            evt = '{vld: 1'b1, kind: KIND_DROP};
          end else if (crc_r != rcrc_r) begin
            evt = '{vld: 1'b1, kind: KIND_CRC_ERR};
          end else begin
            evt = '{vld: 1'b1, kind: KIND_GOOD};
          end
        end
      endcase
    end

    dlen_rpt = dlen_nxt;
    if (frm_rst) begin
      phase_nxt = PH_HEADER;
      esc_nxt   = 1'b0;
      crc_nxt   = CRC_INIT;
      fbc_nxt   = '0;
      fidx_nxt  = '0;
      dlen_nxt  = '0;
    end
  end

  // result payload
  always_comb begin : result_out
    res_kind  = evt.kind;
    res_digit = (evt.kind == KIND_PARAM) ? bd : '0;
    res_cmd   = (evt.kind == KIND_GOOD) ? cmd_r : '0;
    res_crc   = (evt.kind == KIND_CRC_ERR) ? crc_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      own_addr_r <= OWN_ADDR_RST;
      max_len_r  <= MAX_LEN_RST;
      phase_r    <= PH_HEADER;
      esc_r      <= 1'b0;
      crc_r      <= CRC_INIT;
      fbc_r      <= '0;
      fidx_r     <= '0;
      dlen_r     <= '0;
      sender_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_OWN_ADDR: own_addr_r <= cfg_wdata;
          CFG_MAX_LEN:  max_len_r  <= cfg_wdata[LEN_W-1:0];
        endcase
      end

      if (adv) begin
        phase_r  <= phase_nxt;
        esc_r    <= esc_nxt;
        crc_r    <= crc_nxt;
        fbc_r    <= fbc_nxt;
        fidx_r   <= fidx_nxt;
        dlen_r   <= dlen_nxt;
        sender_r <= sender_nxt;
      end

      if (adv && evt.vld) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv) begin
      recv_r <= recv_nxt;
      cmd_r  <= cmd_nxt;
      rcrc_r <= rcrc_nxt;
    end
    if (adv && evt.vld) begin
      out_kind_r   <= res_kind;
      out_digit_r  <= res_digit;
      out_sender_r <= sender_nxt;
      out_cmd_r    <= res_cmd;
      out_count_r  <= dlen_rpt;
      out_crc_r    <= res_crc;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_kind_r;
  assign out_param_digit  = out_digit_r;
  assign out_sender       = out_sender_r;
  assign out_command_word = out_cmd_r;
  assign out_param_count  = out_count_r;
  assign out_computed_crc = out_crc_r;

  `ASSERT_IMPLIES(a_hdr_iff_empty, clk, rst_n, 1'b1, ((phase_r == PH_HEADER) == (fbc_r == '0)), "header phase and byte count disagree")
  `ASSERT_IMPLIES(a_esc_in_frame, clk, rst_n, esc_r, fbc_r != '0, "escape pending outside a frame")
  `ASSERT_IMPLIES(a_param_idx, clk, rst_n, phase_r == PH_PARAM, (dlen_r != '0) && (fidx_r < dlen_r), "parameter index out of range")
  `ASSERT_NEXT(a_result_loaded, clk, rst_n, adv && evt.vld, out_vld_r, "result lost on transfer")

endmodule

### tb/sfr_frame_check.sv
// Result checker for the stuffed frame receiver: byte-level deframing predictor and comparison
module sfr_frame_check
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [KIND_W-1:0] out_kind,
  input  logic [BYTE_W-1:0] out_param_digit,
  input  logic [ADDR_W-1:0] out_sender,
  input  logic [CMD_W-1:0]  out_command_word,
  input  logic [LEN_W-1:0]  out_param_count,
  input  logic [CRC_W-1:0]  out_computed_crc,
  input  logic              cfg_wr_en,
  input  cfg_idx_t          cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] digit;
    logic [ADDR_W-1:0] sender;
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  count;
    logic [CRC_W-1:0]  crc;
  } frame_result_t;

  frame_result_t     awaited[$];
  frame_result_t     exp_r;
  int                errs = 0;

  logic [ADDR_W-1:0] own_addr;
  logic [LEN_W-1:0]  max_len;

  phase_t            ph;
  logic              esc;
  logic [CRC_W-1:0]  body_crc;
  logic [LEN_W-1:0]  nbytes;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  dlen;
  logic [ADDR_W-1:0] sender_q;
  logic [ADDR_W-1:0] recv_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [CRC_W-1:0]  rx_crc;

  assign fail_count = errs;

  function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  task automatic clear_frame();
    ph       = PH_HEADER;
    esc      = 1'b0;
    body_crc = CRC_INIT;
    nbytes   = '0;
    idx      = '0;
    dlen     = '0;
  endtask

  task automatic post(input kind_t k, input logic [BYTE_W-1:0] d, input logic [CMD_W-1:0] c,
                      input logic [CRC_W-1:0] cr);
    frame_result_t r;
    r.kind    = k;
    r.digit   = d;
    r.sender  = sender_q;
    r.command = c;
    r.count   = dlen;
    r.crc     = cr;
    awaited.push_back(r);
  endtask

  task automatic drop_frame(input kind_t k);
    post(k, '0, '0, '0);
    clear_frame();
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] b;
    logic [3:0]        nib;
    logic              hex_ok;
    b = raw;
    if (b == CH_NUL) begin
      post(KIND_NULL, '0, '0, '0);
      return;
    end
    if (nbytes == '0 && b != CH_OPEN) return;
    if (nbytes != '0 && b == CH_OPEN) clear_frame();
    if (nbytes != '0 && nbytes < MIN_FRAME_BYTES && b == CH_CLOSE) begin
      drop_frame(KIND_SHORT);
      return;
    end
    if (nbytes != '0 && b == CH_TILDE) begin
      esc = 1'b1;
      return;
    end
    if (esc) begin
      case (b)
        CH_LBRK:  b = CH_OPEN;
        CH_RBRK:  b = CH_CLOSE;
        CH_CARET: b = CH_TILDE;
        default: begin
          drop_frame(KIND_ESC_ERR);
          return;
        end
      endcase
      esc = 1'b0;
    end
    if (ph >= PH_SENDER && ph <= PH_PARAM) body_crc = crc_next(body_crc, b);

    case (ph)
      PH_HEADER: begin
        nbytes = 10'd1;
        ph     = PH_SENDER;
      end
      PH_SENDER: begin
        nbytes++;
        sender_q = {sender_q[ADDR_W-9:0], b};
        idx++;
        if (idx >= ADDR_BYTES) begin
          idx = '0;
          ph  = PH_RECEIVER;
        end
      end
      PH_RECEIVER: begin
        nbytes++;
        recv_q = {recv_q[ADDR_W-9:0], b};
        idx++;
        if (idx >= ADDR_BYTES) begin
          if (recv_q != own_addr) begin
            drop_frame(KIND_DROP);
            return;
          end
          idx = '0;
          ph  = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (b < CH_ZERO || b > CH_NINE) begin
          drop_frame(KIND_DROP);
          return;
        end
        nbytes++;
        if (idx == '0) dlen = '0;
        dlen = dlen * 10'd10 + {2'b00, b - CH_ZERO};
        idx++;
        if (idx >= LEN_DIGITS) begin
          if (dlen > max_len) begin
            drop_frame(KIND_LEN_ERR);
            return;
          end
          idx = '0;
          ph  = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        nbytes++;
        cmd_q = {cmd_q[CMD_W-9:0], b};
        idx++;
        if (idx >= CMD_BYTES) begin
          idx = '0;
          ph  = (dlen == '0) ? PH_CRC : PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (b < CH_ZERO || b > CH_NINE) begin
          drop_frame(KIND_DROP);
          return;
        end
        nbytes++;
        post(KIND_PARAM, b, '0, '0);
        idx++;
        if (idx >= dlen) begin
          idx = '0;
          ph  = PH_CRC;
        end
      end
      PH_CRC: begin
        hex_ok = 1'b1;
        nib    = '0;
        if (b >= CH_ZERO && b <= CH_NINE) nib = 4'(b - CH_ZERO);
        else if (b >= CH_UA && b <= CH_UF) nib = 4'(b - CH_UA) + 4'd10;
        else if (b >= CH_LA && b <= CH_LF) nib = 4'(b - CH_LA) + 4'd10;
        else hex_ok = 1'b0;
        if (!hex_ok) begin
          drop_frame(KIND_DROP);
          return;
        end
        nbytes++;
        if (idx == '0) rx_crc = '0;
        rx_crc = {rx_crc[CRC_W-5:0], nib};
        idx++;
        if (idx >= CRC_DIGITS) begin
          idx = '0;
          ph  = PH_FOOTER;
        end
      end
      default: begin
        if (b != CH_CLOSE) begin
          drop_frame(KIND_DROP);
          return;
        end
        if (body_crc != rx_crc) post(KIND_CRC_ERR, '0, '0, body_crc);
        else post(KIND_GOOD, '0, cmd_q, '0);
        clear_frame();
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited.delete();
      own_addr = OWN_ADDR_RST;
      max_len  = MAX_LEN_RST;
      clear_frame();
      sender_q = '0;
      recv_q   = '0;
      cmd_q    = '0;
      rx_crc   = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          errs++;
          $error("unexpected result transfer: kind %0d", out_kind);
        end else begin
          exp_r = awaited.pop_front();
          if (out_kind !== exp_r.kind) begin
            errs++;
            $error("kind: expected %0d, actual %0d", exp_r.kind, out_kind);
          end
          if (out_param_digit !== exp_r.digit) begin
            errs++;
            $error("param_digit: expected %0h, actual %0h", exp_r.digit, out_param_digit);
          end
          if (out_sender !== exp_r.sender) begin
            errs++;
            $error("sender: expected %0h, actual %0h", exp_r.sender, out_sender);
          end
          if (out_command_word !== exp_r.command) begin
            errs++;
            $error("command_word: expected %0h, actual %0h", exp_r.command, out_command_word);
          end
          if (out_param_count !== exp_r.count) begin
            errs++;
            $error("param_count: expected %0d, actual %0d", exp_r.count, out_param_count);
          end
          if (out_computed_crc !== exp_r.crc) begin
            errs++;
            $error("computed_crc: expected %0h, actual %0h", exp_r.crc, out_computed_crc);
          end
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_OWN_ADDR) own_addr = cfg_wdata;
        else max_len = cfg_wdata[LEN_W-1:0];
      end
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
    end
    outstanding <= awaited.size();
  end

endmodule

### tb/stuffed_frame_receiver_crc16_tb.sv
// Testbench top for the stuffed frame receiver: frame stimulus, idling, config phases, verdict
module stuffed_frame_receiver_crc16_tb;
  import sfr_pkg::*;

  typedef enum int {
    FLT_NONE,
    FLT_CRC,
    FLT_MUTATE,
    FLT_NULL,
    FLT_RESTART,
    FLT_CUT,
    FLT_TILDE
  } fault_t;

  localparam int ITEM_TARGET   = 820;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LIMIT_CYCLES  = 400000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_param_digit;
  logic [ADDR_W-1:0] out_sender;
  logic [CMD_W-1:0]  out_command_word;
  logic [LEN_W-1:0]  out_param_count;
  logic [CRC_W-1:0]  out_computed_crc;
  logic              cfg_wr_en;
  cfg_idx_t          cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;

  int                fail_count;
  int                outstanding;
  int                in_gap_pct;
  int                out_stall_pct;
  int                sent;
  logic [ADDR_W-1:0] own_addr_cur;
  logic [LEN_W-1:0]  max_len_cur;

  stuffed_frame_receiver_crc16 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_param_digit  (out_param_digit),
    .out_sender       (out_sender),
    .out_command_word (out_command_word),
    .out_param_count  (out_param_count),
    .out_computed_crc (out_computed_crc),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  sfr_frame_check frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_param_digit  (out_param_digit),
    .out_sender       (out_sender),
    .out_command_word (out_command_word),
    .out_param_count  (out_param_count),
    .out_computed_crc (out_computed_crc),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  always #10 clk = ~clk;

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("[stuffed_frame_receiver_crc16] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < out_stall_pct);
  end

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c;
    for (int k = 7; k >= 0; k--) begin
      if (r[CRC_W-1] ^ b[k]) r = (r << 1) ^ CRC_POLY;
      else r = r << 1;
    end
    return r;
  endfunction

  // four random bytes, none of them zero
  function automatic logic [31:0] nz_word();
    logic [31:0] w;
    for (int i = 0; i < 4; i++) w[i*8 +: 8] = 8'($urandom_range(1, 255));
    return w;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        in_gap_pct    = 9;
        out_stall_pct = 57;
      end
      1: begin
        in_gap_pct    = 57;
        out_stall_pct = 9;
      end
      default: begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
    endcase
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // drop valid and wait until every awaited result has been taken
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [ADDR_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_OWN_ADDR) own_addr_cur = val;
    else max_len_cur = val[LEN_W-1:0];
  endtask

  // pos 0 picks a random spot; params and trailer only go out if len is acceptable
  task automatic send_frame(input logic [ADDR_W-1:0] from, input logic [ADDR_W-1:0] to,
                            input int len, input logic [CMD_W-1:0] cmd, input fault_t flt,
                            input int pos, input logic [BYTE_W-1:0] val, input bit esc_footer);
    logic [BYTE_W-1:0] body[$];
    logic [BYTE_W-1:0] raw[$];
    logic [CRC_W-1:0]  crc;
    logic [3:0]        nib;
    for (int i = 2; i >= 0; i--) body.push_back(from[i*8 +: 8]);
    for (int i = 2; i >= 0; i--) body.push_back(to[i*8 +: 8]);
    body.push_back(CH_ZERO + 8'(len / 100));
    body.push_back(CH_ZERO + 8'((len / 10) % 10));
    body.push_back(CH_ZERO + 8'(len % 10));
    for (int i = 3; i >= 0; i--) body.push_back(cmd[i*8 +: 8]);
    if (len <= max_len_cur)
      for (int i = 0; i < len; i++) body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    crc = CRC_INIT;
    foreach (body[i]) crc = crc_step(crc, body[i]);
    if (flt == FLT_CRC) crc = crc ^ 16'($urandom_range(1, 65535));

    raw.push_back(CH_OPEN);
    foreach (body[i]) begin
      if (body[i] == CH_OPEN) begin
        raw.push_back(CH_TILDE);
        raw.push_back(CH_LBRK);
      end else if (body[i] == CH_CLOSE) begin
        raw.push_back(CH_TILDE);
        raw.push_back(CH_RBRK);
      end else if (body[i] == CH_TILDE) begin
        raw.push_back(CH_TILDE);
        raw.push_back(CH_CARET);
      end else begin
        raw.push_back(body[i]);
      end
    end
    if (len <= max_len_cur) begin
      for (int i = 3; i >= 0; i--) begin
        nib = crc[i*4 +: 4];
        if (nib < 4'd10) raw.push_back(CH_ZERO + 8'(nib));
        else raw.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(nib) - 8'd10);
      end
      if (esc_footer) begin
        raw.push_back(CH_TILDE);
        raw.push_back(CH_RBRK);
      end else begin
        raw.push_back(CH_CLOSE);
      end
    end

    if (pos == 0) pos = $urandom_range(1, raw.size() - 1);
    case (flt)
      FLT_MUTATE:  raw[pos] = val;
      FLT_NULL:    raw.insert(pos, CH_NUL);
      FLT_RESTART: raw.insert(pos, CH_OPEN);
      FLT_TILDE:   raw.insert(pos, CH_TILDE);
      FLT_CUT: begin
        while (raw.size() > pos) raw.delete(raw.size() - 1);
        raw.push_back(CH_CLOSE);
      end
      default: ;
    endcase
    foreach (raw[i]) push_byte(raw[i]);
  endtask

  task automatic send_random_frame();
    int          r;
    int          len;
    int          lim;
    fault_t      flt;
    logic [31:0] from_w;
    logic [31:0] to_w;
    lim = (max_len_cur > 40) ? 40 : int'(max_len_cur);
    r = $urandom_range(0, 99);
    if (r < 80) len = $urandom_range(0, (lim < 8) ? lim : 8);
    else if (r < 92 || max_len_cur == 10'd999) len = $urandom_range(0, lim);
    else len = $urandom_range(int'(max_len_cur) + 1, 999);
    from_w = nz_word();
    to_w   = nz_word();
    if ($urandom_range(0, 99) < 95) to_w[ADDR_W-1:0] = own_addr_cur;
    r = $urandom_range(0, 99);
    if (r < 62) flt = FLT_NONE;
    else if (r < 70) flt = FLT_CRC;
    else if (r < 80) flt = FLT_MUTATE;
    else if (r < 85) flt = FLT_NULL;
    else if (r < 90) flt = FLT_RESTART;
    else if (r < 95) flt = FLT_CUT;
    else flt = FLT_TILDE;
    // line noise between frames
    if ($urandom_range(0, 99) < 15)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
    send_frame(from_w[ADDR_W-1:0], to_w[ADDR_W-1:0], len, nz_word(), flt, 0,
               8'($urandom_range(1, 255)), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int          seg;
    int          prog;
    int          base;
    logic [31:0] w;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_OWN_ADDR;
    cfg_wdata    = '0;
    sent         = 0;
    own_addr_cur = OWN_ADDR_RST;
    max_len_cur  = MAX_LEN_RST;
    set_idling(0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: null, idle bytes, stuffing, every drop path
    push_byte(CH_NUL);
    push_byte(8'h41);
    push_byte(8'hFF);
    send_frame(24'hFF7B01, own_addr_cur, 0, 32'h7D7E5B41, FLT_NONE, 0, '0, 1'b1);
    send_frame(24'hFF7B01, own_addr_cur, 0, 32'h7D7E5B41, FLT_TILDE, 2, '0, 1'b0);
    send_frame(24'h414243, own_addr_cur, 3, 32'h5A5A5A5A, FLT_NONE, 0, '0, 1'b0);
    send_frame(24'h414243, own_addr_cur, 2, 32'h44454647, FLT_CRC, 0, '0, 1'b0);
    send_frame(24'h414243, 24'h535441, 1, 32'h44454647, FLT_NONE, 0, '0, 1'b0);
    send_frame(24'h414243, own_addr_cur, 701, 32'h44454647, FLT_NONE, 0, '0, 1'b0);
    send_frame(24'h414243, own_addr_cur, 700, 32'h44454647, FLT_CUT, 30, '0, 1'b0);
    send_frame(24'h414243, own_addr_cur, 1, 32'h44454647, FLT_CUT, 5, '0, 1'b0);
    send_frame(24'h414243, own_addr_cur, 1, 32'h44454647, FLT_TILDE, 3, '0, 1'b0);
    send_frame(24'h414243, own_addr_cur, 1, 32'h44454647, FLT_RESTART, 8, '0, 1'b0);
    send_frame(24'h414243, own_addr_cur, 3, 32'h44454647, FLT_MUTATE, 8, 8'h78, 1'b0);
    send_frame(24'h414243, own_addr_cur, 3, 32'h44454647, FLT_MUTATE, 15, 8'h5A, 1'b0);
    send_frame(24'h414243, own_addr_cur, 0, 32'h44454647, FLT_MUTATE, 15, 8'h47, 1'b0);
    send_frame(24'h414243, own_addr_cur, 0, 32'h44454647, FLT_MUTATE, 18, 8'h3E, 1'b0);
    send_frame(24'h414243, own_addr_cur, 2, 32'h44454647, FLT_NULL, 10, '0, 1'b0);
    write_reg(CFG_OWN_ADDR, '0);
    send_frame(24'h414243, OWN_ADDR_RST, 1, 32'h44454647, FLT_NONE, 0, '0, 1'b0);
    write_reg(CFG_OWN_ADDR, OWN_ADDR_RST);

    // random frames over several register settings and idling profiles
    seg  = 0;
    base = sent;
    while (sent - base < ITEM_TARGET) begin
      prog = sent - base;
      set_idling(prog * 3 / ITEM_TARGET);
      if (prog * 5 / ITEM_TARGET != seg) begin
        seg = prog * 5 / ITEM_TARGET;
        w   = nz_word();
        case (seg)
          1: begin
            write_reg(CFG_OWN_ADDR, w[ADDR_W-1:0]);
            write_reg(CFG_MAX_LEN, ADDR_W'(999));
          end
          2: begin
            write_reg(CFG_OWN_ADDR, 24'hFFFFFF);
            write_reg(CFG_MAX_LEN, '0);
          end
          3: begin
            write_reg(CFG_OWN_ADDR, w[ADDR_W-1:0]);
            write_reg(CFG_MAX_LEN, ADDR_W'($urandom_range(1, 30)));
          end
          default: begin
            write_reg(CFG_OWN_ADDR, OWN_ADDR_RST);
            write_reg(CFG_MAX_LEN, ADDR_W'(MAX_LEN_RST));
          end
        endcase
        // longest accepted length, cut short when large, then one over the limit
        send_frame(w[ADDR_W-1:0], own_addr_cur, max_len_cur, nz_word(),
                   (max_len_cur > 12) ? FLT_CUT : FLT_NONE, (max_len_cur > 12) ? 30 : 0,
                   '0, 1'b0);
        if (max_len_cur < 10'd999)
          send_frame(w[ADDR_W-1:0], own_addr_cur, int'(max_len_cur) + 1, nz_word(),
                     FLT_NONE, 0, '0, 1'b0);
      end
      send_random_frame();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[stuffed_frame_receiver_crc16] OK");
    end else begin
      $display("[stuffed_frame_receiver_crc16] ERROR");
    end
    $finish;
  end

endmodule
